>>> design/semaphore_bank_fifo_waiters_macros.svh
// Assertion macros for the file that checks its own logic.
`ifndef SEMAPHORE_BANK_FIFO_WAITERS_MACROS_SVH
`define SEMAPHORE_BANK_FIFO_WAITERS_MACROS_SVH

`ifndef SYNTH

`define SBFW_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbfw: same-cycle check failed");

`define SBFW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbfw: next-cycle check failed");

`else

`define SBFW_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define SBFW_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> design/sbfw_pkg.sv
package sbfw_pkg;

   localparam int NUM_SEMS_DEF    = 8;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int ACTION_W  = 2;
   localparam int SEM_IDX_W = 3;
   localparam int TASK_W    = 8;
   localparam int COUNT_W   = 16;
   localparam int KIND_W    = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   localparam int FIFO_SLOTS  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_SLOTS);
   localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ACQUIRE     = 2'd0,
      ACT_RELEASE     = 2'd1,
      ACT_ACQUIRE_ALL = 2'd2,
      ACT_INIT        = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_GRANT   = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_REFUSED = 2'd2
   } kind_type;

   typedef struct packed {
      action_type           action;
      logic [SEM_IDX_W-1:0] sem;
      logic [TASK_W-1:0]    task_id;
      logic [COUNT_W-1:0]   init_count;
   } item_type;

endpackage

>>> design/sbfw_ram.sv
module sbfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sbfw_front.sv
module sbfw_front #(
   parameter int NUM_SEMS = sbfw_pkg::NUM_SEMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sbfw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [sbfw_pkg::ACTION_W-1:0]   req_tuser,
   output logic                            item_valid,
   output sbfw_pkg::item_type              item,
   input  logic                            item_pop
);

   sbfw_pkg::item_type                    slot_ff [sbfw_pkg::FIFO_SLOTS];
   logic [sbfw_pkg::FIFO_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sbfw_pkg::FIFO_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sbfw_pkg::FIFO_CNT_W-1:0]       count_ff, count_in;
   sbfw_pkg::item_type                    beat_item;
   logic                                  in_range;
   logic                                  push;

   always_comb begin
      beat_item.action     = sbfw_pkg::action_type'(req_tuser);
      beat_item.sem        = req_tdata[2:0];
      beat_item.task_id    = req_tdata[10:3];
      beat_item.init_count = req_tdata[26:11];
   end

   // A beat addressing a semaphore beyond the bank is taken and dropped here.
   assign in_range   = 7'(beat_item.sem) < 7'(NUM_SEMS);
   assign req_tready = count_ff != sbfw_pkg::FIFO_CNT_W'(sbfw_pkg::FIFO_SLOTS);
   assign push       = req_tvalid && req_tready && in_range;
   assign item_valid = count_ff != '0;
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= beat_item;
      end
   end

endmodule

>>> design/sbfw_back.sv
module sbfw_back #(
   parameter int NUM_SEMS    = sbfw_pkg::NUM_SEMS_DEF,
   parameter int QUEUE_DEPTH = sbfw_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  sbfw_pkg::item_type            item,
   output logic                          item_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sbfw_pkg::TASK_W-1:0]   rsp_task,
   output sbfw_pkg::kind_type            rsp_kind,
   output logic [sbfw_pkg::SEM_IDX_W-1:0] rsp_sem,
   output logic                          rsp_last
);

   localparam int SEM_W       = NUM_SEMS > 1 ? $clog2(NUM_SEMS) : 1;
   localparam int QW          = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = QW + 1;
   localparam int CW          = sbfw_pkg::COUNT_W;
   localparam int ST_W        = CW + QW + QW + FILL_W;
   localparam int STORE_DEPTH = NUM_SEMS * QUEUE_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_REPLY = 4'b0100,
      ST_SPARE = 4'b1000
   } fsm_type;

   fsm_type                        state_ff, state_in;
   sbfw_pkg::item_type             item_ff, item_in;
   logic [NUM_SEMS-1:0]            sem_valid_ff, sem_valid_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic                           first_ff, first_in;
   sbfw_pkg::kind_type             first_kind_ff, first_kind_in;
   logic                           grant_ff, grant_in;
   logic                           bypass_ff, bypass_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sbfw_pkg::TASK_W-1:0]    rsp_task_ff, rsp_task_in;
   sbfw_pkg::kind_type             rsp_kind_ff, rsp_kind_in;
   logic [sbfw_pkg::SEM_IDX_W-1:0] rsp_sem_ff, rsp_sem_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [SEM_W+sbfw_pkg::SEM_IDX_W-1:0] head_wide, cur_wide;
   logic [SEM_W-1:0]               head_sem, cur_sem;
   logic [ST_W-1:0]                st_rdata, st_wdata;
   logic                           st_we;
   logic [CW-1:0]                  cnt0, cnt1, cnt2;
   logic [QW-1:0]                  head0, tail0, head1, tail1;
   logic [FILL_W-1:0]              fill0, fill1, fill2;
   logic                           is_full, enqueue;
   logic [ADDR_W-1:0]              store_base, store_waddr, store_raddr;
   logic                           store_re;
   logic [sbfw_pkg::TASK_W-1:0]    store_rdata;
   logic                           out_free;

   assign head_wide = (SEM_W + sbfw_pkg::SEM_IDX_W)'(item.sem);
   assign head_sem  = head_wide[SEM_W-1:0];
   assign cur_wide  = (SEM_W + sbfw_pkg::SEM_IDX_W)'(item_ff.sem);
   assign cur_sem   = cur_wide[SEM_W-1:0];

   assign item_pop = (state_ff == ST_IDLE) && item_valid;

   sbfw_ram #(
      .WIDTH (ST_W),
      .DEPTH (NUM_SEMS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (cur_sem),
      .wr_data (st_wdata),
      .rd_en   (item_pop),
      .rd_addr (head_sem),
      .rd_data (st_rdata)
   );

   sbfw_ram #(
      .WIDTH (sbfw_pkg::TASK_W),
      .DEPTH (STORE_DEPTH)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (enqueue),
      .wr_addr (store_waddr),
      .wr_data (item_ff.task_id),
      .rd_en   (store_re),
      .rd_addr (store_raddr),
      .rd_data (store_rdata)
   );

   // A semaphore never written since reset reads as all zero.
   always_comb begin
      if (rd_valid_ff) begin
         {cnt0, head0, tail0, fill0} = st_rdata;
      end else begin
         {cnt0, head0, tail0, fill0} = '0;
      end
   end

   always_comb begin
      is_full = fill0 == FILL_W'(QUEUE_DEPTH);
      enqueue = 1'b0;
      cnt1    = cnt0;
      tail1   = tail0;
      fill1   = fill0;
      case (item_ff.action)
         sbfw_pkg::ACT_RELEASE: begin
            if (cnt0 != sbfw_pkg::COUNT_MAX) begin
               cnt1 = cnt0 + 1'b1;
            end
         end
         sbfw_pkg::ACT_ACQUIRE, sbfw_pkg::ACT_ACQUIRE_ALL: begin
            if (item_ff.action == sbfw_pkg::ACT_ACQUIRE_ALL && cnt0 != '0) begin
               cnt1 = CW'(1);
            end
            if (!is_full) begin
               enqueue = state_ff == ST_EXEC;
               tail1   = (tail0 == QW'(QUEUE_DEPTH - 1)) ? '0 : tail0 + 1'b1;
               fill1   = fill0 + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      grant_in = (item_ff.action != sbfw_pkg::ACT_INIT) && (cnt1 != '0) && (fill1 != '0);
      cnt2     = cnt1;
      head1    = head0;
      fill2    = fill1;
      if (grant_in) begin
         cnt2  = cnt1 - 1'b1;
         head1 = (head0 == QW'(QUEUE_DEPTH - 1)) ? '0 : head0 + 1'b1;
         fill2 = fill1 - 1'b1;
      end
      if (item_ff.action == sbfw_pkg::ACT_INIT) begin
         st_wdata = {item_ff.init_count, {QW{1'b0}}, {QW{1'b0}}, {FILL_W{1'b0}}};
      end else begin
         st_wdata = {cnt2, head1, tail1, fill2};
      end
   end

   assign st_we       = state_ff == ST_EXEC;
   assign store_base  = ADDR_W'(ADDR_W'(cur_sem) * ADDR_W'(QUEUE_DEPTH));
   assign store_waddr = store_base + ADDR_W'(tail0);
   assign store_raddr = store_base + ADDR_W'(head0);
   assign store_re    = (state_ff == ST_EXEC) && grant_in;
   assign out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      sem_valid_in  = sem_valid_ff;
      rd_valid_in   = rd_valid_ff;
      first_in      = first_ff;
      first_kind_in = first_kind_ff;
      grant_ff_hold: begin
      end
      bypass_in     = bypass_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_sem_in    = rsp_sem_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_in     = item;
               rd_valid_in = sem_valid_ff[head_sem];
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            sem_valid_in[cur_sem] = 1'b1;
            // The grant reads the entry just written when the queue was empty.
            bypass_in = fill0 == '0;
            first_in  = (item_ff.action == sbfw_pkg::ACT_RELEASE) ||
                        ((item_ff.action == sbfw_pkg::ACT_ACQUIRE ||
                          item_ff.action == sbfw_pkg::ACT_ACQUIRE_ALL) && is_full);
            first_kind_in = (item_ff.action == sbfw_pkg::ACT_RELEASE) ?
                            sbfw_pkg::KIND_ACK : sbfw_pkg::KIND_REFUSED;
            if (first_in || grant_in) begin
               state_in = ST_REPLY;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sem_in   = item_ff.sem;
               if (first_ff) begin
                  rsp_task_in = item_ff.task_id;
                  rsp_kind_in = first_kind_ff;
                  rsp_last_in = !grant_ff;
                  first_in    = 1'b0;
                  if (!grant_ff) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_task_in = bypass_ff ? item_ff.task_id : store_rdata;
                  rsp_kind_in = sbfw_pkg::KIND_GRANT;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sem_valid_ff <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sem_valid_ff <= sem_valid_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      rd_valid_ff   <= rd_valid_in;
      first_kind_ff <= first_kind_in;
      bypass_ff     <= bypass_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_sem_ff    <= rsp_sem_in;
      rsp_last_ff   <= rsp_last_in;
      if (state_ff == ST_EXEC) begin
         grant_ff <= grant_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_task   = rsp_task_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_sem    = rsp_sem_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> design/semaphore_bank_fifo_waiters.sv
// Channel   Ports   Beat carries
// request   req_    tuser action; tdata sem_index, task_id, init_count
// response  rsp_    tuser reply_kind; tlast last; tdata reply_task, reply_sem
//
// In the engine an item first reads the semaphore's count and queue pointers
// from the state memory, then updates them and the waiter memory.
// Each reply beat then passes through the output register.
// A four-entry queue lets requests keep arriving while the engine or the
// response side stalls. Reset is synchronous and needs no clearing pass.
`include "semaphore_bank_fifo_waiters_macros.svh"

module semaphore_bank_fifo_waiters #(
   parameter int NUM_SEMS    = sbfw_pkg::NUM_SEMS_DEF,
   parameter int QUEUE_DEPTH = sbfw_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sem_index, task_id, init_count, zero fill
   input  logic [sbfw_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [sbfw_pkg::ACTION_W-1:0]   req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // reply_task, reply_sem, zero fill
   output logic [sbfw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // reply_kind
   output logic [sbfw_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                            rsp_tlast
);

   logic                           item_valid;
   sbfw_pkg::item_type             item;
   logic                           item_pop;
   logic [sbfw_pkg::TASK_W-1:0]    rsp_task;
   sbfw_pkg::kind_type             rsp_kind;
   logic [sbfw_pkg::SEM_IDX_W-1:0] rsp_sem;

   sbfw_front #(
      .NUM_SEMS (NUM_SEMS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   sbfw_back #(
      .NUM_SEMS    (NUM_SEMS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_task   (rsp_task),
      .rsp_kind   (rsp_kind),
      .rsp_sem    (rsp_sem),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, rsp_sem, rsp_task};
   assign rsp_tuser = rsp_kind;

   `SBFW_ASSERT_SAME(a_pop_needs_item, clock, reset, item_pop, item_valid)
   `SBFW_ASSERT_NEXT(a_no_back_to_back_pop, clock, reset, item_pop, !item_pop)
   `SBFW_ASSERT_SAME(a_stall_only_when_queued, clock, reset, !req_tready, item_valid)
   `SBFW_ASSERT_SAME(a_grant_is_last, clock, reset,
                     rsp_tvalid && rsp_kind == sbfw_pkg::KIND_GRANT, rsp_tlast)

endmodule
